>>> rtl/core/tbps_pkg.sv
// package: shared constants, codes and types of the token bucket packet shaper
`timescale 1ns / 1ps
package tbps_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int SIZE_BITS       = 16;
  localparam int CFG_BITS        = 16;
  localparam int APB_ADDR_BITS   = 3;
  localparam int APB_DATA_BITS   = 32;

  localparam logic [CFG_BITS-1:0] CAPACITY_RESET = 16'd15;
  localparam logic [CFG_BITS-1:0] RATE_RESET     = 16'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_RATE     = 1'b1;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    EV_SENT_NOW   = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_SENT_QUEUE = 3'd2,
    EV_REJECTED   = 3'd3,
    EV_DROPPED    = 3'd4,
    EV_TICK_DONE  = 3'd5
  } event_kind_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_PKT      = 4'b0010,
    S_TICK_ADD = 4'b0100,
    S_TICK_CHK = 4'b1000
  } state_t;

endpackage

>>> rtl/core/tbps_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/token_bucket_packet_shaper.sv
// token bucket packet shaper: top level with sequencer, shared compare unit and wait queue
// An item is taken when start is high and busy is low. A packet item keeps busy high for one
// cycle and its single result appears on the cycle after. A tick item keeps busy high through
// a saturating add state, then one check state per packet popped from the head of the wait
// queue (one shared compare and subtract unit checks the head against the tokens in each
// check state), then a final check state for the tick done
// result. Results come one per cycle, each shown for one cycle with result_valid; the receiver
// cannot stall them. The wait queue sits in a ram read at the next head, so no clearing pass is
// needed after reset. Registers: capacity at byte address 0, rate at byte address 4.
`timescale 1ns / 1ps
module token_bucket_packet_shaper
  import tbps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd,
  input  logic [SIZE_BITS-1:0]     packet_size,
  output logic                     result_valid,
  output logic [2:0]               event_kind,
  output logic [SIZE_BITS-1:0]     sent_size,
  output logic [SIZE_BITS-1:0]     tokens_left,
  output logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;

  state_t state, state_next;

  logic [CFG_BITS-1:0]   bucket_capacity;
  logic [CFG_BITS-1:0]   token_rate;
  logic [COUNT_BITS-1:0] token_count, token_count_next;
  logic [IW-1:0]         queue_head, queue_head_next;
  logic [IW-1:0]         queue_tail, queue_tail_next;
  logic [FW-1:0]         queue_fill, queue_fill_next;
  logic [SIZE_BITS-1:0]  item_size;

  logic                  ram_we;
  logic [SIZE_BITS-1:0]  ram_rdata;

  logic [SIZE_BITS-1:0]  operand;
  logic [WW:0]           diff;
  logic                  covers;
  logic [WW:0]           sum;
  logic [WW:0]           cap_ext;
  logic [WW:0]           cmax_ext;
  logic [WW:0]           sat_cap;
  logic [WW:0]           sat;
  logic [WW-1:0]         left_ext;

  logic                  emit;
  event_kind_t           ev_kind;
  logic [SIZE_BITS-1:0]  ev_size;
  logic                  ev_last;
  logic                  cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity <= CAPACITY_RESET;
      token_rate      <= RATE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CAPACITY) begin
        bucket_capacity <= pwdata[CFG_BITS-1:0];
      end else begin
        token_rate <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DATA_BITS'(bucket_capacity);
    end else begin
      prdata = APB_DATA_BITS'(token_rate);
    end
  end

  // shared compare and subtract unit
  assign operand = (state == S_PKT) ? item_size : ram_rdata;
  assign diff    = {1'b0, WW'(token_count)} - {1'b0, WW'(operand)};
  assign covers  = ~diff[WW];

  // saturating tick add
  assign sum      = {1'b0, WW'(token_count)} + {1'b0, WW'(token_rate)};
  assign cap_ext  = (WW + 1)'(bucket_capacity);
  assign cmax_ext = (WW + 1)'({COUNT_BITS{1'b1}});
  assign sat_cap  = (sum > cap_ext) ? cap_ext : sum;
  assign sat      = (sat_cap > cmax_ext) ? cmax_ext : sat_cap;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    token_count_next = token_count;
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    queue_fill_next  = queue_fill;
    ram_we           = 1'b0;
    emit             = 1'b0;
    ev_kind          = EV_TICK_DONE;
    ev_size          = '0;
    ev_last          = 1'b1;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (cmd == CMD_TICK) ? S_TICK_ADD : S_PKT;
        end
      end
      S_PKT: begin
        emit    = 1'b1;
        ev_size = item_size;
        if (item_size == '0) begin
          ev_kind = EV_REJECTED;
        end else if (covers) begin
          ev_kind          = EV_SENT_NOW;
          token_count_next = diff[COUNT_BITS-1:0];
        end else if (queue_fill == FW'(QUEUE_DEPTH)) begin
          ev_kind = EV_DROPPED;
        end else begin
          ev_kind         = EV_QUEUED;
          ram_we          = 1'b1;
          queue_tail_next = (queue_tail == IW'(QUEUE_DEPTH - 1)) ? '0 : queue_tail + 1'b1;
          queue_fill_next = queue_fill + 1'b1;
        end
        state_next = S_IDLE;
      end
      S_TICK_ADD: begin
        token_count_next = sat[COUNT_BITS-1:0];
        state_next       = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        emit = 1'b1;
        if ((queue_fill != '0) && covers) begin
          ev_kind          = EV_SENT_QUEUE;
          ev_size          = ram_rdata;
          ev_last          = 1'b0;
          token_count_next = diff[COUNT_BITS-1:0];
          queue_head_next  = (queue_head == IW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;
          queue_fill_next  = queue_fill - 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      token_count <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_fill  <= '0;
    end else begin
      state       <= state_next;
      token_count <= token_count_next;
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      queue_fill  <= queue_fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_size <= packet_size;
    end
  end

  // read at the next head so the head entry is ready every cycle
  tbps_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (queue_tail),
    .wdata (item_size),
    .raddr (queue_head_next),
    .rdata (ram_rdata)
  );

  // result transaction
  assign left_ext = WW'(token_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind  <= ev_kind;
      sent_size   <= ev_size;
      tokens_left <= left_ext[SIZE_BITS-1:0];
      last        <= ev_last;
    end
  end

endmodule

>>> verif/tbps_checker.sv
// checker for the token bucket packet shaper: predicts every result and compares it
`timescale 1ns / 1ps
module tbps_checker
  import tbps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     cmd,
  input  logic [SIZE_BITS-1:0]     packet_size,
  input  logic                     result_valid,
  input  logic [2:0]               event_kind,
  input  logic [SIZE_BITS-1:0]     sent_size,
  input  logic [SIZE_BITS-1:0]     tokens_left,
  input  logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic [APB_DATA_BITS-1:0] prdata,
  input  logic                     pready,
  output int                       fail_count,
  output int                       pending_count,
  output int                       results_checked
);

  typedef struct packed {
    event_kind_t          kind;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] tokens;
    logic                 last;
  } shaper_event_t;

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS_DEF) - 33'd1;

  logic [CFG_BITS-1:0]       capacity;
  logic [CFG_BITS-1:0]       rate;
  logic [COUNT_BITS_DEF-1:0] tokens;
  logic [SIZE_BITS-1:0]      wait_fifo [QUEUE_DEPTH_DEF];
  int                        fifo_head;
  int                        fifo_tail;
  int                        fifo_fill;
  shaper_event_t             expected_events [$];
  int                        fails = 0;
  int                        checked = 0;

  task automatic note_event(event_kind_t kind, logic [SIZE_BITS-1:0] size, logic fin);
    shaper_event_t ev;
    ev.kind   = kind;
    ev.size   = size;
    ev.tokens = tokens[SIZE_BITS-1:0];
    ev.last   = fin;
    expected_events.push_back(ev);
  endtask

  task automatic shape_tick();
    logic [32:0] sum;
    sum = 33'(tokens) + 33'(rate);
    if (sum > 33'(capacity)) sum = 33'(capacity);
    if (sum > COUNT_MAX) sum = COUNT_MAX;
    tokens = sum[COUNT_BITS_DEF-1:0];
    // drain from the head while the tokens cover it
    while (fifo_fill > 0 && tokens >= COUNT_BITS_DEF'(wait_fifo[fifo_head])) begin
      tokens = tokens - COUNT_BITS_DEF'(wait_fifo[fifo_head]);
      note_event(EV_SENT_QUEUE, wait_fifo[fifo_head], 1'b0);
      fifo_head = (fifo_head + 1) % QUEUE_DEPTH_DEF;
      fifo_fill--;
    end
    note_event(EV_TICK_DONE, '0, 1'b1);
  endtask

  task automatic shape_packet(logic [SIZE_BITS-1:0] size);
    if (size == '0) begin
      note_event(EV_REJECTED, '0, 1'b1);
    end else if (tokens >= COUNT_BITS_DEF'(size)) begin
      tokens = tokens - COUNT_BITS_DEF'(size);
      note_event(EV_SENT_NOW, size, 1'b1);
    end else if (fifo_fill >= QUEUE_DEPTH_DEF) begin
      note_event(EV_DROPPED, size, 1'b1);
    end else begin
      wait_fifo[fifo_tail] = size;
      fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH_DEF;
      fifo_fill++;
      note_event(EV_QUEUED, size, 1'b1);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    shaper_event_t ev;
    if (expected_events.size() == 0) begin
      $error("result transaction with nothing expected: event_kind %0d sent_size %0d",
             event_kind, sent_size);
      fails++;
    end else begin
      ev = expected_events.pop_front();
      checked++;
      check_field("event_kind", 32'(ev.kind), 32'(event_kind));
      check_field("sent_size", 32'(ev.size), 32'(sent_size));
      check_field("tokens_left", 32'(ev.tokens), 32'(tokens_left));
      check_field("last", 32'(ev.last), 32'(last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity  = CAPACITY_RESET;
      rate      = RATE_RESET;
      tokens    = '0;
      fifo_head = 0;
      fifo_tail = 0;
      fifo_fill = 0;
      expected_events.delete();
    end else begin
      if (result_valid) compare_result();
      if (start && !busy) begin
        if (cmd == CMD_TICK) shape_tick();
        else shape_packet(packet_size);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_CAPACITY) capacity = pwdata[CFG_BITS-1:0];
          else rate = pwdata[CFG_BITS-1:0];
        end else begin
          check_field("prdata", (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'(rate),
                      prdata);
        end
      end
    end
    fail_count      <= fails;
    pending_count   <= expected_events.size();
    results_checked <= checked;
  end

endmodule

>>> verif/testbench.sv
// top of the token bucket packet shaper testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import tbps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     cmd = CMD_PACKET;
  logic [SIZE_BITS-1:0]     packet_size = '0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;

  logic                     busy;
  logic                     result_valid;
  logic [2:0]               event_kind;
  logic [SIZE_BITS-1:0]     sent_size;
  logic [SIZE_BITS-1:0]     tokens_left;
  logic                     last;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending_count;
  int results_checked;
  int cycles = 0;
  int packets_sent = 0;
  int ticks_sent = 0;
  int settings_used = 1;
  logic burst = 1'b0;
  logic [CFG_BITS-1:0] cur_cap = CAPACITY_RESET;

  always #5 clk = ~clk;

  token_bucket_packet_shaper dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .packet_size(packet_size),
    .result_valid(result_valid), .event_kind(event_kind), .sent_size(sent_size),
    .tokens_left(tokens_left), .last(last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tbps_checker shaper_watch (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .packet_size(packet_size),
    .result_valid(result_valid), .event_kind(event_kind), .sent_size(sent_size),
    .tokens_left(tokens_left), .last(last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending_count(pending_count),
    .results_checked(results_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("token_bucket_packet_shaper verification failed");
      $finish;
    end
  end

  task automatic apb_access(logic wr, logic [APB_ADDR_BITS-1:0] addr,
                            logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write both registers with junk in the unused upper bits, then read them back
  task automatic set_shaping(logic [CFG_BITS-1:0] cap, logic [CFG_BITS-1:0] rt);
    apb_access(1'b1, {REG_CAPACITY, 2'b00}, {16'($urandom), cap});
    apb_access(1'b1, {REG_RATE, 2'b00}, {16'($urandom), rt});
    apb_access(1'b0, {REG_CAPACITY, 2'b00}, '0);
    apb_access(1'b0, {REG_RATE, 2'b00}, '0);
    cur_cap = cap;
    settings_used++;
  endtask

  task automatic send_item(logic c, logic [SIZE_BITS-1:0] size);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= c;
    packet_size <= size;
    do @(posedge clk); while (busy);
    if (c == CMD_TICK) ticks_sent++;
    else packets_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_items(int n, int tick_pct);
    logic [SIZE_BITS-1:0] size;
    int span;
    span = (cur_cap == 0) ? 8 : ((cur_cap > 4096) ? 4096 : int'(cur_cap));
    repeat (n) begin
      if ($urandom_range(1, 100) <= tick_pct) begin
        send_item(CMD_TICK, 16'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       size = '0;
          1:       size = 16'($urandom);
          2:       size = 16'hFFFF;
          default: size = 16'($urandom_range(1, span));
        endcase
        send_item(CMD_PACKET, size);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero size, queue and drain, oversized head, send past waiting
    send_item(CMD_PACKET, 16'd0);
    send_item(CMD_PACKET, 16'd1);
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_PACKET, 16'd2);
    send_item(CMD_PACKET, 16'hFFFF);
    send_item(CMD_PACKET, 16'd4);
    repeat (5) send_item(CMD_TICK, 16'd0);
    send_item(CMD_PACKET, 16'd15);
    send_item(CMD_PACKET, 16'hAAAA);
    send_item(CMD_PACKET, 16'h5555);
    send_item(CMD_TICK, 16'h5555);
    random_items(10, 30);
    wait_idle();

    set_shaping(16'hFFFF, 16'hFFFF);
    send_item(CMD_TICK, 16'hAAAA);
    send_item(CMD_TICK, 16'd0);
    random_items(8, 30);
    wait_idle();

    // capacity below the count, no refill
    set_shaping(16'd1, 16'd0);
    random_items(18, 10);
    wait_idle();

    set_shaping(16'd0, 16'hFFFF);
    random_items(8, 30);
    wait_idle();

    set_shaping(16'hFFFF, 16'hFFFF);
    burst = 1'b1;
    random_items(10, 40);
    wait_idle();

    burst = 1'b0;
    set_shaping(16'd1000, 16'd100);
    random_items(14, 35);
    wait_idle();

    set_shaping(16'hFFFF, 16'd1);
    random_items(10, 30);
    wait_idle();

    burst = 1'b1;
    set_shaping(16'($urandom_range(1, 300)), 16'($urandom_range(0, 80)));
    random_items(14, 30);
    wait_idle();

    burst = 1'b0;
    set_shaping(16'($urandom), 16'($urandom));
    random_items(8, 30);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("summary: %0d packet and %0d tick transactions under %0d shaping settings",
             packets_sent, ticks_sent, settings_used);
    $display("summary: %0d result transactions checked, capacity swept from 0 to 65535",
             results_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("token_bucket_packet_shaper verification clean");
    end else begin
      $display("token_bucket_packet_shaper verification failed");
    end
    $finish;
  end

endmodule
